// ===== rtl/core/sosfg_pkg.sv =====
`timescale 1ns / 1ps

package sosfg_pkg;

    // Table and arithmetic geometry
    localparam int MAX_SINUSOIDS  = 32;
    localparam int COS_TABLE_BITS = 10;
    localparam int ADDR_W = (MAX_SINUSOIDS > 1) ? $clog2(MAX_SINUSOIDS) : 1;
    localparam int CNT_W  = $clog2(MAX_SINUSOIDS + 1);
    localparam int QWAVE  = 1 << (COS_TABLE_BITS - 2);
    localparam int QW_W   = COS_TABLE_BITS - 1;
    localparam int SUM_W  = 16 + $clog2(MAX_SINUSOIDS + 1);
    localparam int PROD_W = SUM_W + 17;

    // Field widths
    localparam int IDX_W   = 5;
    localparam int WORD_W  = 32;
    localparam int NUM_W   = 6;
    localparam int GAIN_W  = 16;
    localparam int CFG_W   = 16;
    localparam int OUT_W   = 24;
    localparam int ENTRY_W = 4 * WORD_W;

    // Output scaling: Q29 -> Q18 with round half up
    localparam int RND_SHIFT = 11;

    // Register reset values
    localparam logic [NUM_W-1:0]  NUM_RESET  = 6'd8;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd16384;

    // Item kinds
    localparam logic KIND_LOAD   = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    // Configuration register indexes
    typedef enum logic [0:0] {
        CFG_NUM_SINUSOIDS = 1'b0,
        CFG_GAIN          = 1'b1
    } t_cfg_reg;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_SCALE,
        ST_OUT
    } t_state;

    // Cosine quarter wave, built at elaboration
    localparam logic [63:0] PI_Q28 = 64'd843314857;
    localparam logic [63:0] SER_DIV [12] = '{
        64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132,
        64'd182, 64'd240, 64'd306, 64'd380, 64'd462, 64'd552
    };

    typedef logic [14:0] t_qwave [QWAVE+1];

    function automatic t_qwave build_wave();
        t_qwave             w;
        logic [63:0]        a;
        logic [63:0]        a2;
        logic [63:0]        term;
        logic [63:0]        v;
        logic signed [63:0] s;
        for (int k = 0; k <= QWAVE; k++) begin
            a    = (64'd2 * PI_Q28 * 64'(k) + (64'd1 << (COS_TABLE_BITS - 1)))
                   >> COS_TABLE_BITS;
            a2   = (a * a) >> 28;
            term = 64'd1 << 28;
            s    = 64'sd1 <<< 28;
            for (int n = 0; n < 12; n++) begin
                term = (term * a2) >> 28;
                term = term / SER_DIV[n];
                if ((n % 2) == 0) begin
                    s = s - $signed(term);
                end else begin
                    s = s + $signed(term);
                end
            end
            v = (s < 0) ? 64'd0 : $unsigned(s);
            v = (v * 64'd32767 + (64'd1 << 27)) >> 28;
            w[k] = (v > 64'd32767) ? 15'd32767 : v[14:0];
        end
        return w;
    endfunction

    localparam t_qwave QWAVE_ROM = build_wave();

    // Full-wave cosine from the top phase bits, signed Q1.15
    function automatic logic signed [15:0] wave_cos(input logic [WORD_W-1:0] ph);
        logic [COS_TABLE_BITS-1:0] idx;
        logic [1:0]                quad;
        logic [QW_W-1:0]           r;
        logic [QW_W-1:0]           m;
        logic signed [15:0]        direct;
        logic signed [15:0]        mirror;
        logic signed [15:0]        res;
        idx    = ph[WORD_W-1 -: COS_TABLE_BITS];
        quad   = idx[COS_TABLE_BITS-1 -: 2];
        r      = {1'b0, idx[COS_TABLE_BITS-3:0]};
        m      = QW_W'(QWAVE) - r;
        direct = $signed({1'b0, QWAVE_ROM[r]});
        mirror = $signed({1'b0, QWAVE_ROM[m]});
        case (quad)
            2'd0:    res = direct;
            2'd1:    res = -mirror;
            2'd2:    res = -direct;
            default: res = mirror;
        endcase
        return res;
    endfunction

endpackage

// ===== rtl/core/sum_of_sinusoids_fading_generator.sv =====
`timescale 1ns / 1ps

// Channel     | Handshake               | Word
// ------------+-------------------------+-------------------------------------------
// input       | i_valid / o_ready       | i_kind, i_entry_index, i_freq_*, i_phase_*,
//             |                         | i_sample_index, i_last_sample
// output      | o_valid / i_ready       | o_out_real, o_out_imag, o_last
// config      | i_cfg_we (no wait)      | i_cfg_index, i_cfg_data
//
// A load word writes its table entry at the accepting edge.
// A sample word sums N = min(num_sinusoids, 32) table entries: the sinusoid
// table RAM is read one entry per cycle, and each entry runs through multiply,
// phase add, cosine lookup and accumulate before the gain multiply and rounding.
// With N = 0 there is no table pass; the sequencer goes through drain to scale.
// Reset clears the sequencer, output valid and the config registers; the table
// is not cleared. A stalled output holds its word while the next input is taken
// and processed; only the final write into the output register waits.
module sum_of_sinusoids_fading_generator (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input channel
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic                                i_kind,
    input  logic [sosfg_pkg::IDX_W-1:0]         i_entry_index,
    input  logic signed [sosfg_pkg::WORD_W-1:0] i_freq_real,
    input  logic signed [sosfg_pkg::WORD_W-1:0] i_freq_imag,
    input  logic [sosfg_pkg::WORD_W-1:0]        i_phase_real,
    input  logic [sosfg_pkg::WORD_W-1:0]        i_phase_imag,
    input  logic [sosfg_pkg::WORD_W-1:0]        i_sample_index,
    input  logic                                i_last_sample,
    // output channel
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [sosfg_pkg::OUT_W-1:0]  o_out_real,
    output logic signed [sosfg_pkg::OUT_W-1:0]  o_out_imag,
    output logic                                o_last,
    // configuration port
    input  logic                                i_cfg_we,
    input  logic [0:0]                          i_cfg_index,
    input  logic [sosfg_pkg::CFG_W-1:0]         i_cfg_data
);
    import sosfg_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [NUM_W-1:0]  r_num;
    logic [GAIN_W-1:0] r_gain;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num  <= NUM_RESET;
            r_gain <= GAIN_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_index))
                CFG_NUM_SINUSOIDS: r_num  <= i_cfg_data[NUM_W-1:0];
                CFG_GAIN:          r_gain <= i_cfg_data[GAIN_W-1:0];
                default:           ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    t_state r_state;
    t_state n_state;

    logic in_acc;
    logic load_acc;
    logic sample_acc;
    logic slot_free;
    logic rd_en;
    logic mul_en;
    logic out_load;
    logic pipe_busy;

    logic [ADDR_W-1:0] r_addr;
    logic [ADDR_W-1:0] r_last_addr;
    logic [CNT_W-1:0]  cnt;
    logic              last_issue;

    logic r_v1, r_v2, r_v3, r_v4;

    assign in_acc     = i_valid && o_ready;
    assign load_acc   = in_acc && (i_kind == KIND_LOAD);
    assign sample_acc = in_acc && (i_kind == KIND_SAMPLE);
    assign slot_free  = !o_valid || i_ready;
    assign pipe_busy  = r_v1 || r_v2 || r_v3 || r_v4;
    assign last_issue = (r_addr == r_last_addr);

    // Entries summed: clamp the register to the table depth
    always_comb begin
        if (int'(r_num) > MAX_SINUSOIDS) begin
            cnt = CNT_W'(MAX_SINUSOIDS);
        end else begin
            cnt = CNT_W'(r_num);
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (sample_acc) begin
                    n_state = (cnt == '0) ? ST_DRAIN : ST_RUN;
                end
            end
            ST_RUN: begin
                if (last_issue) n_state = ST_DRAIN;
            end
            ST_DRAIN: begin
                if (!pipe_busy) n_state = ST_SCALE;
            end
            ST_SCALE: n_state = ST_OUT;
            ST_OUT: begin
                if (slot_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_ready  = 1'b0;
        rd_en    = 1'b0;
        mul_en   = 1'b0;
        out_load = 1'b0;
        case (r_state)
            ST_IDLE:  o_ready  = 1'b1;
            ST_RUN:   rd_en    = 1'b1;
            ST_DRAIN: ;
            ST_SCALE: mul_en   = 1'b1;
            ST_OUT:   out_load = slot_free;
            default:  ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Hold the sample context for the whole pass
    logic [WORD_W-1:0] r_n;
    logic              r_last;

    always_ff @(posedge i_clk) begin
        if (sample_acc) begin
            r_n         <= i_sample_index;
            r_last      <= i_last_sample;
            r_last_addr <= ADDR_W'(cnt - CNT_W'(1));
            r_addr      <= '0;
        end else if (rd_en) begin
            r_addr <= r_addr + ADDR_W'(1);
        end
    end

    // ------------------------------------------------------------------
    // Sinusoid table RAM: freq_real, freq_imag, phase_real, phase_imag
    // ------------------------------------------------------------------
    logic [ENTRY_W-1:0] mem [MAX_SINUSOIDS];
    logic [ENTRY_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        // drop loads beyond the table
        if (load_acc && (int'(i_entry_index) < MAX_SINUSOIDS)) begin
            mem[ADDR_W'(i_entry_index)] <= {i_phase_imag, i_phase_real,
                                            i_freq_imag, i_freq_real};
        end
        if (rd_en) begin
            r_rd_data <= mem[r_addr];
        end
    end

    // ------------------------------------------------------------------
    // Per-entry pipeline: multiply, phase add, cosine, accumulate
    // ------------------------------------------------------------------
    logic [WORD_W-1:0]       r_mul_re, r_mul_im;
    logic [WORD_W-1:0]       r_ph0_re, r_ph0_im;
    logic [WORD_W-1:0]       r_ph_re, r_ph_im;
    logic signed [15:0]      r_cos_re, r_cos_im;
    logic signed [SUM_W-1:0] r_acc_re, r_acc_im;
    logic signed [SUM_W-1:0] n_acc_re, n_acc_im;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= rd_en;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    // phase wraps mod 2^32, so the low product bits serve signed frequencies too
    always_ff @(posedge i_clk) begin
        r_mul_re <= WORD_W'(r_n * r_rd_data[WORD_W-1:0]);
        r_mul_im <= WORD_W'(r_n * r_rd_data[2*WORD_W-1:WORD_W]);
        r_ph0_re <= r_rd_data[3*WORD_W-1:2*WORD_W];
        r_ph0_im <= r_rd_data[4*WORD_W-1:3*WORD_W];
        r_ph_re  <= r_mul_re + r_ph0_re;
        r_ph_im  <= r_mul_im + r_ph0_im;
        r_cos_re <= wave_cos(r_ph_re);
        r_cos_im <= wave_cos(r_ph_im);
    end

    always_comb begin
        n_acc_re = r_acc_re;
        n_acc_im = r_acc_im;
        if (sample_acc) begin
            n_acc_re = '0;
            n_acc_im = '0;
        end else if (r_v4) begin
            n_acc_re = r_acc_re + SUM_W'(r_cos_re);
            n_acc_im = r_acc_im + SUM_W'(r_cos_im);
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc_re <= n_acc_re;
        r_acc_im <= n_acc_im;
    end

    // ------------------------------------------------------------------
    // Gain, rounding and saturation
    // ------------------------------------------------------------------
    logic signed [PROD_W-1:0] r_prod_re, r_prod_im;

    always_ff @(posedge i_clk) begin
        if (mul_en) begin
            r_prod_re <= PROD_W'(r_acc_re * $signed({1'b0, r_gain}));
            r_prod_im <= PROD_W'(r_acc_im * $signed({1'b0, r_gain}));
        end
    end

    // floor((p + half) / 2^11) equals an arithmetic shift after the bias
    function automatic logic signed [OUT_W-1:0] round_sat(
        input logic signed [PROD_W-1:0] p
    );
        logic signed [PROD_W:0]           b;
        logic signed [PROD_W-RND_SHIFT:0] q;
        logic signed [OUT_W-1:0]          res;
        b = (PROD_W+1)'(p) + (PROD_W+1)'(1 << (RND_SHIFT - 1));
        q = b[PROD_W:RND_SHIFT];
        if (q > (PROD_W-RND_SHIFT+1)'((1 << (OUT_W - 1)) - 1)) begin
            res = {1'b0, {(OUT_W-1){1'b1}}};
        end else if (q < -(PROD_W-RND_SHIFT+1)'(1 << (OUT_W - 1))) begin
            res = {1'b1, {(OUT_W-1){1'b0}}};
        end else begin
            res = q[OUT_W-1:0];
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Output register: holds the word until taken
    // ------------------------------------------------------------------
    logic                    r_o_valid;
    logic signed [OUT_W-1:0] r_o_real, r_o_imag;
    logic                    r_o_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (out_load) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_o_real <= round_sat(r_prod_re);
            r_o_imag <= round_sat(r_prod_im);
            r_o_last <= r_last;
        end
    end

    assign o_valid    = r_o_valid;
    assign o_out_real = r_o_real;
    assign o_out_imag = r_o_imag;
    assign o_last     = r_o_last;

endmodule
